FILE: hdl/mhe_pkg.sv
`default_nettype none
package mhe_pkg;

   localparam int RAD_W = 64;
   localparam int ROOT_W = 32;
   localparam int DIVD_W = 64;
   localparam int DIVS_W = 32;
   localparam int WORD_W = 32;
   localparam int PROD_W = 64;
   localparam int ACC_W = 67;
   localparam int MEM_DEPTH = 32;
   localparam int PC_W = 6;

   typedef logic [4:0] addr_type;

   localparam addr_type A_Q0 = 5'd0;
   localparam addr_type A_Q1 = 5'd1;
   localparam addr_type A_Q2 = 5'd2;
   localparam addr_type A_Q3 = 5'd3;
   localparam addr_type A_F0 = 5'd4;
   localparam addr_type A_F1 = 5'd5;
   localparam addr_type A_F2 = 5'd6;
   localparam addr_type A_U0 = 5'd7;
   localparam addr_type A_U1 = 5'd8;
   localparam addr_type A_U2 = 5'd9;
   localparam addr_type A_A11 = 5'd10;
   localparam addr_type A_A12 = 5'd11;
   localparam addr_type A_A13 = 5'd12;
   localparam addr_type A_A21 = 5'd13;
   localparam addr_type A_A22 = 5'd14;
   localparam addr_type A_A23 = 5'd15;
   localparam addr_type A_A31 = 5'd16;
   localparam addr_type A_A32 = 5'd17;
   localparam addr_type A_A33 = 5'd18;
   localparam addr_type A_HX = 5'd19;
   localparam addr_type A_HY = 5'd20;
   localparam addr_type A_BZ = 5'd21;
   localparam addr_type A_BX = 5'd22;
   localparam addr_type A_W0 = 5'd23;
   localparam addr_type A_W1 = 5'd24;
   localparam addr_type A_W2 = 5'd25;
   localparam addr_type A_V0 = 5'd26;
   localparam addr_type A_V1 = 5'd27;
   localparam addr_type A_V2 = 5'd28;
   localparam addr_type A_E0 = 5'd29;
   localparam addr_type A_E1 = 5'd30;
   localparam addr_type A_E2 = 5'd31;

   typedef enum logic [2:0] {
      OP_MAC,
      OP_SQRT,
      OP_SQRT30,
      OP_DIV,
      OP_CHKZ,
      OP_END
   } op_kind_type;

   typedef enum logic [1:0] {
      INIT_KEEP,
      INIT_ZERO,
      INIT_ONE
   } acc_init_type;

   typedef struct packed {
      op_kind_type kind;
      acc_init_type init;
      logic rnd;
      logic dbl;
      logic sub;
      logic wr;
      logic hi;
      addr_type ra;
      addr_type rb;
      addr_type dst;
   } uop_type;

   function automatic uop_type mac(input acc_init_type init, input logic rnd, input logic dbl,
                                   input logic sub, input logic wr, input addr_type ra,
                                   input addr_type rb, input addr_type dst);
      uop_type u;
      u = '0;
      u.kind = OP_MAC;
      u.init = init;
      u.rnd = rnd;
      u.dbl = dbl;
      u.sub = sub;
      u.wr = wr;
      u.ra = ra;
      u.rb = rb;
      u.dst = dst;
      return u;
   endfunction

   function automatic uop_type ctl(input op_kind_type kind, input logic wr, input logic hi,
                                   input addr_type ra, input addr_type dst);
      uop_type u;
      u = '0;
      u.kind = kind;
      u.init = INIT_KEEP;
      u.wr = wr;
      u.hi = hi;
      u.ra = ra;
      u.rb = ra;
      u.dst = dst;
      return u;
   endfunction

   // Microprogram of the sequencer.
   function automatic uop_type prog(input logic [PC_W-1:0] pc);
      uop_type u;
      case (pc)
         6'd0: u = mac(INIT_ZERO, 1'b0, 1'b0, 1'b0, 1'b0, A_F0, A_F0, A_F0);
         6'd1: u = mac(INIT_KEEP, 1'b0, 1'b0, 1'b0, 1'b0, A_F1, A_F1, A_F0);
         6'd2: u = mac(INIT_KEEP, 1'b0, 1'b0, 1'b0, 1'b0, A_F2, A_F2, A_F0);
         6'd3: u = ctl(OP_SQRT30, 1'b0, 1'b0, A_F0, A_F0);
         6'd4: u = ctl(OP_DIV, 1'b1, 1'b1, A_F0, A_U0);
         6'd5: u = ctl(OP_DIV, 1'b1, 1'b1, A_F1, A_U1);
         6'd6: u = ctl(OP_DIV, 1'b1, 1'b1, A_F2, A_U2);
         6'd7: u = mac(INIT_ONE, 1'b1, 1'b1, 1'b1, 1'b0, A_Q2, A_Q2, A_A11);
         6'd8: u = mac(INIT_KEEP, 1'b1, 1'b1, 1'b1, 1'b1, A_Q3, A_Q3, A_A11);
         6'd9: u = mac(INIT_ZERO, 1'b1, 1'b1, 1'b0, 1'b0, A_Q1, A_Q2, A_A12);
         6'd10: u = mac(INIT_KEEP, 1'b1, 1'b1, 1'b1, 1'b1, A_Q0, A_Q3, A_A12);
         6'd11: u = mac(INIT_ZERO, 1'b1, 1'b1, 1'b0, 1'b0, A_Q1, A_Q3, A_A13);
         6'd12: u = mac(INIT_KEEP, 1'b1, 1'b1, 1'b0, 1'b1, A_Q0, A_Q2, A_A13);
         6'd13: u = mac(INIT_ZERO, 1'b1, 1'b1, 1'b0, 1'b0, A_Q1, A_Q2, A_A21);
         6'd14: u = mac(INIT_KEEP, 1'b1, 1'b1, 1'b0, 1'b1, A_Q0, A_Q3, A_A21);
         6'd15: u = mac(INIT_ONE, 1'b1, 1'b1, 1'b1, 1'b0, A_Q1, A_Q1, A_A22);
         6'd16: u = mac(INIT_KEEP, 1'b1, 1'b1, 1'b1, 1'b1, A_Q3, A_Q3, A_A22);
         6'd17: u = mac(INIT_ZERO, 1'b1, 1'b1, 1'b0, 1'b0, A_Q2, A_Q3, A_A23);
         6'd18: u = mac(INIT_KEEP, 1'b1, 1'b1, 1'b1, 1'b1, A_Q0, A_Q1, A_A23);
         6'd19: u = mac(INIT_ZERO, 1'b1, 1'b1, 1'b0, 1'b0, A_Q1, A_Q3, A_A31);
         6'd20: u = mac(INIT_KEEP, 1'b1, 1'b1, 1'b1, 1'b1, A_Q0, A_Q2, A_A31);
         6'd21: u = mac(INIT_ZERO, 1'b1, 1'b1, 1'b0, 1'b0, A_Q2, A_Q3, A_A32);
         6'd22: u = mac(INIT_KEEP, 1'b1, 1'b1, 1'b0, 1'b1, A_Q0, A_Q1, A_A32);
         6'd23: u = mac(INIT_ONE, 1'b1, 1'b1, 1'b1, 1'b0, A_Q1, A_Q1, A_A33);
         6'd24: u = mac(INIT_KEEP, 1'b1, 1'b1, 1'b1, 1'b1, A_Q2, A_Q2, A_A33);
         6'd25: u = mac(INIT_ZERO, 1'b1, 1'b0, 1'b0, 1'b0, A_A11, A_U0, A_HX);
         6'd26: u = mac(INIT_KEEP, 1'b1, 1'b0, 1'b0, 1'b0, A_A12, A_U1, A_HX);
         6'd27: u = mac(INIT_KEEP, 1'b1, 1'b0, 1'b0, 1'b1, A_A13, A_U2, A_HX);
         6'd28: u = mac(INIT_ZERO, 1'b1, 1'b0, 1'b0, 1'b0, A_A21, A_U0, A_HY);
         6'd29: u = mac(INIT_KEEP, 1'b1, 1'b0, 1'b0, 1'b0, A_A22, A_U1, A_HY);
         6'd30: u = mac(INIT_KEEP, 1'b1, 1'b0, 1'b0, 1'b1, A_A23, A_U2, A_HY);
         6'd31: u = mac(INIT_ZERO, 1'b1, 1'b0, 1'b0, 1'b0, A_A31, A_U0, A_BZ);
         6'd32: u = mac(INIT_KEEP, 1'b1, 1'b0, 1'b0, 1'b0, A_A32, A_U1, A_BZ);
         6'd33: u = mac(INIT_KEEP, 1'b1, 1'b0, 1'b0, 1'b1, A_A33, A_U2, A_BZ);
         6'd34: u = mac(INIT_ZERO, 1'b0, 1'b0, 1'b0, 1'b0, A_HX, A_HX, A_BX);
         6'd35: u = mac(INIT_KEEP, 1'b0, 1'b0, 1'b0, 1'b0, A_HY, A_HY, A_BX);
         6'd36: u = ctl(OP_SQRT, 1'b1, 1'b0, A_BX, A_BX);
         6'd37: u = mac(INIT_ZERO, 1'b1, 1'b0, 1'b0, 1'b0, A_BX, A_A11, A_W0);
         6'd38: u = mac(INIT_KEEP, 1'b1, 1'b0, 1'b0, 1'b1, A_BZ, A_A31, A_W0);
         6'd39: u = mac(INIT_ZERO, 1'b1, 1'b0, 1'b0, 1'b0, A_BX, A_A12, A_W1);
         6'd40: u = mac(INIT_KEEP, 1'b1, 1'b0, 1'b0, 1'b1, A_BZ, A_A32, A_W1);
         6'd41: u = mac(INIT_ZERO, 1'b1, 1'b0, 1'b0, 1'b0, A_BX, A_A13, A_W2);
         6'd42: u = mac(INIT_KEEP, 1'b1, 1'b0, 1'b0, 1'b1, A_BZ, A_A33, A_W2);
         6'd43: u = mac(INIT_ZERO, 1'b0, 1'b0, 1'b0, 1'b0, A_W0, A_W0, A_W0);
         6'd44: u = mac(INIT_KEEP, 1'b0, 1'b0, 1'b0, 1'b0, A_W1, A_W1, A_W0);
         6'd45: u = mac(INIT_KEEP, 1'b0, 1'b0, 1'b0, 1'b0, A_W2, A_W2, A_W0);
         6'd46: u = ctl(OP_SQRT, 1'b0, 1'b0, A_W0, A_W0);
         6'd47: u = ctl(OP_CHKZ, 1'b0, 1'b0, A_W0, A_W0);
         6'd48: u = ctl(OP_DIV, 1'b1, 1'b0, A_W0, A_V0);
         6'd49: u = ctl(OP_DIV, 1'b1, 1'b0, A_W1, A_V1);
         6'd50: u = ctl(OP_DIV, 1'b1, 1'b0, A_W2, A_V2);
         6'd51: u = mac(INIT_ZERO, 1'b1, 1'b0, 1'b0, 1'b0, A_U1, A_V2, A_E0);
         6'd52: u = mac(INIT_KEEP, 1'b1, 1'b0, 1'b1, 1'b1, A_U2, A_V1, A_E0);
         6'd53: u = mac(INIT_ZERO, 1'b1, 1'b0, 1'b0, 1'b0, A_U2, A_V0, A_E1);
         6'd54: u = mac(INIT_KEEP, 1'b1, 1'b0, 1'b1, 1'b1, A_U0, A_V2, A_E1);
         6'd55: u = mac(INIT_ZERO, 1'b1, 1'b0, 1'b0, 1'b0, A_U0, A_V1, A_E2);
         6'd56: u = mac(INIT_KEEP, 1'b1, 1'b0, 1'b1, 1'b1, A_U1, A_V0, A_E2);
         default: u = ctl(OP_END, 1'b0, 1'b0, A_Q0, A_Q0);
      endcase
      return u;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/mhe_mul.sv
`default_nettype none
module mhe_mul (
   input  logic                                clock,
   input  logic signed [mhe_pkg::WORD_W-1:0]   mul_a,
   input  logic signed [mhe_pkg::WORD_W-1:0]   mul_b,
   output logic signed [mhe_pkg::PROD_W-1:0]   mul_prod
);
   import mhe_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   assign mul_prod = prod_ff;

endmodule
`default_nettype wire

FILE: hdl/mhe_sqrt.sv
`default_nettype none
module mhe_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [mhe_pkg::RAD_W-1:0]     radicand,
   output logic                          busy,
   output logic [mhe_pkg::ROOT_W-1:0]    root
);
   import mhe_pkg::*;

   logic [RAD_W-1:0]    x_ff;
   logic [ROOT_W+3:0]   rem_ff;
   logic [ROOT_W-1:0]   root_ff;
   logic [5:0]          cnt_ff;
   logic [ROOT_W+3:0]   rem_sh;
   logic [ROOT_W+3:0]   trial;
   logic                ge;

   assign rem_sh = {rem_ff[ROOT_W+1:0], x_ff[RAD_W-1 -: 2]};
   assign trial = {2'b00, root_ff, 2'b01};
   assign ge = (rem_sh >= trial);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         x_ff <= radicand;
         rem_ff <= '0;
         root_ff <= '0;
         cnt_ff <= 6'(ROOT_W);
      end else if (cnt_ff != '0) begin
         x_ff <= {x_ff[RAD_W-3:0], 2'b00};
         rem_ff <= ge ? (rem_sh - trial) : rem_sh;
         root_ff <= {root_ff[ROOT_W-2:0], ge};
         cnt_ff <= cnt_ff - 6'd1;
      end
   end

   assign busy = (cnt_ff != '0);
   assign root = root_ff;

endmodule
`default_nettype wire

FILE: hdl/mhe_div.sv
`default_nettype none
module mhe_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [mhe_pkg::DIVD_W-1:0]    dividend,
   input  logic [mhe_pkg::DIVS_W-1:0]    divisor,
   output logic                          busy,
   output logic [mhe_pkg::DIVD_W-1:0]    quotient
);
   import mhe_pkg::*;

   logic [DIVD_W-1:0]   n_ff;
   logic [DIVS_W-1:0]   d_ff;
   logic [DIVS_W-1:0]   rem_ff;
   logic [6:0]          cnt_ff;
   logic [DIVS_W:0]     rem_sh;
   logic [DIVS_W:0]     diff;
   logic                ge;

   assign rem_sh = {rem_ff, n_ff[DIVD_W-1]};
   assign diff = rem_sh - {1'b0, d_ff};
   assign ge = (rem_sh >= {1'b0, d_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         n_ff <= dividend;
         d_ff <= divisor;
         rem_ff <= '0;
         cnt_ff <= 7'(DIVD_W);
      end else if (cnt_ff != '0) begin
         n_ff <= {n_ff[DIVD_W-2:0], ge};
         rem_ff <= ge ? diff[DIVS_W-1:0] : rem_sh[DIVS_W-1:0];
         cnt_ff <= cnt_ff - 7'd1;
      end
   end

   assign busy = (cnt_ff != '0);
   assign quotient = n_ff;

endmodule
`default_nettype wire

FILE: hdl/magnetic_heading_error_unit.sv
`default_nettype none
// Magnetometer heading error for a complementary attitude filter. A request carries a Q1.30
// quaternion, a raw magnetometer sample and its sequence count; the response gives the
// cross-product error and a flag that says whether the sample was used. A sample with an
// unchanged count or all-zero axes is skipped, and its response is offered in the cycle after
// the request is taken. A used sample is processed one request at a time: the sequencer
// runs 47 multiply-accumulate steps, each a fetch, multiply and accumulate state, on the shared
// multiplier, three 32-step square roots and six 64-step divisions, which take the most time.
module magnetic_heading_error_unit #(
   parameter int FRAC_BITS = 30
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic signed [31:0]  req_quat_w,
   input  logic signed [31:0]  req_quat_x,
   input  logic signed [31:0]  req_quat_y,
   input  logic signed [31:0]  req_quat_z,
   input  logic signed [15:0]  req_field_x,
   input  logic signed [15:0]  req_field_y,
   input  logic signed [15:0]  req_field_z,
   input  logic [7:0]          req_sample_count,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [31:0]  rsp_err_x,
   output logic signed [31:0]  rsp_err_y,
   output logic signed [31:0]  rsp_err_z,
   output logic                rsp_fresh
);
   import mhe_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOAD,
      S_FETCH,
      S_MUL,
      S_ACC,
      S_SQRT,
      S_DSTART,
      S_DIV,
      S_DONE
   } state_type;

   localparam int ShHi = FRAC_BITS + 15;
   localparam int ShLo = FRAC_BITS;
   localparam logic signed [PROD_W-1:0] RndBias = PROD_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [ACC_W-1:0] OneAcc = ACC_W'(1) << FRAC_BITS;
   localparam logic signed [ACC_W-1:0] AccMax = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
   localparam logic signed [ACC_W-1:0] AccMin = {{(ACC_W-31){1'b1}}, {31{1'b0}}};
   localparam logic signed [WORD_W-1:0] WordMax = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic signed [WORD_W-1:0] WordMin = {1'b1, {(WORD_W-1){1'b0}}};

   state_type state_ff;
   logic [PC_W-1:0]            pc_ff;
   logic [2:0]                 ld_ff;
   logic [7:0]                 last_ff;
   logic signed [ACC_W-1:0]    acc_ff;
   logic signed [ACC_W-1:0]    acc_in;
   logic [ROOT_W-1:0]          s_ff;
   logic                       neg_ff;
   logic signed [WORD_W-1:0]   err_x_ff;
   logic signed [WORD_W-1:0]   err_y_ff;
   logic signed [WORD_W-1:0]   err_z_ff;
   logic                       fresh_ff;
   logic signed [WORD_W-1:0]   q0_ff;
   logic signed [WORD_W-1:0]   q1_ff;
   logic signed [WORD_W-1:0]   q2_ff;
   logic signed [WORD_W-1:0]   q3_ff;
   logic signed [15:0]         f0_ff;
   logic signed [15:0]         f1_ff;
   logic signed [15:0]         f2_ff;

   logic signed [WORD_W-1:0]   regs_ff [MEM_DEPTH];
   logic signed [WORD_W-1:0]   rda_ff;
   logic signed [WORD_W-1:0]   rdb_ff;
   logic                       mem_we;
   addr_type                   mem_wa;
   logic signed [WORD_W-1:0]   mem_wd;

   uop_type                    uop;
   logic                       skip;
   logic signed [WORD_W-1:0]   ld_val;
   logic signed [PROD_W-1:0]   prod;
   logic signed [PROD_W-1:0]   prod_rnd;
   logic signed [PROD_W-1:0]   term_sel;
   logic signed [ACC_W-1:0]    term_ext;
   logic signed [ACC_W-1:0]    term2;
   logic signed [ACC_W-1:0]    base;
   logic signed [WORD_W-1:0]   acc_sat;

   logic                       sq_start;
   logic [RAD_W-1:0]           sq_rad;
   logic                       sq_busy;
   logic [ROOT_W-1:0]          sq_root;
   logic signed [WORD_W-1:0]   root_sat;

   logic                       dv_start;
   logic [WORD_W-1:0]          dv_mag;
   logic [DIVD_W-1:0]          dv_num;
   logic                       dv_busy;
   logic [DIVD_W-1:0]          dv_quot;
   logic signed [WORD_W-1:0]   dv_sat;

   assign uop = prog(pc_ff);
   assign skip = (req_sample_count == last_ff) ||
                 (req_field_x == '0 && req_field_y == '0 && req_field_z == '0);

   always_comb begin
      case (ld_ff)
         3'd0: ld_val = q0_ff;
         3'd1: ld_val = q1_ff;
         3'd2: ld_val = q2_ff;
         3'd3: ld_val = q3_ff;
         3'd4: ld_val = {{16{f0_ff[15]}}, f0_ff};
         3'd5: ld_val = {{16{f1_ff[15]}}, f1_ff};
         3'd6: ld_val = {{16{f2_ff[15]}}, f2_ff};
         default: ld_val = '0;
      endcase
   end

   mhe_mul u_mul (
      .clock    (clock),
      .mul_a    (rda_ff),
      .mul_b    (rdb_ff),
      .mul_prod (prod)
   );

   assign prod_rnd = (prod + RndBias) >>> FRAC_BITS;
   assign term_sel = uop.rnd ? prod_rnd : prod;
   assign term_ext = {{(ACC_W-PROD_W){term_sel[PROD_W-1]}}, term_sel};
   assign term2 = uop.dbl ? (term_ext <<< 1) : term_ext;

   always_comb begin
      case (uop.init)
         INIT_ZERO: base = '0;
         INIT_ONE: base = OneAcc;
         default: base = acc_ff;
      endcase
   end

   assign acc_in = uop.sub ? (base - term2) : (base + term2);
   assign acc_sat = (acc_in > AccMax) ? WordMax :
                    (acc_in < AccMin) ? WordMin : acc_in[WORD_W-1:0];

   assign sq_start = (state_ff == S_FETCH) && (uop.kind == OP_SQRT || uop.kind == OP_SQRT30);
   assign sq_rad = (uop.kind == OP_SQRT30) ? {acc_ff[33:0], 30'b0} : acc_ff[RAD_W-1:0];

   mhe_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sq_rad),
      .busy     (sq_busy),
      .root     (sq_root)
   );

   assign root_sat = sq_root[ROOT_W-1] ? WordMax : sq_root;

   assign dv_start = (state_ff == S_DSTART);
   assign dv_mag = rda_ff[WORD_W-1] ? (WORD_W'(0) - rda_ff) : rda_ff;
   assign dv_num = uop.hi ? ({32'b0, dv_mag} << ShHi) : ({32'b0, dv_mag} << ShLo);

   mhe_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (dv_start),
      .dividend (dv_num),
      .divisor  (s_ff),
      .busy     (dv_busy),
      .quotient (dv_quot)
   );

   always_comb begin
      if (neg_ff) begin
         dv_sat = (dv_quot > 64'h0000_0000_8000_0000) ? WordMin :
                  (WORD_W'(0) - dv_quot[WORD_W-1:0]);
      end else begin
         dv_sat = (dv_quot > 64'h0000_0000_7fff_ffff) ? WordMax : dv_quot[WORD_W-1:0];
      end
   end

   always_comb begin
      mem_we = 1'b0;
      mem_wa = uop.dst;
      mem_wd = acc_sat;
      case (state_ff)
         S_LOAD: begin
            mem_we = 1'b1;
            mem_wa = {2'b00, ld_ff};
            mem_wd = ld_val;
         end
         S_ACC: begin
            mem_we = uop.wr;
         end
         S_SQRT: begin
            mem_we = uop.wr && !sq_busy;
            mem_wd = root_sat;
         end
         S_DIV: begin
            mem_we = !dv_busy;
            mem_wd = dv_sat;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         regs_ff[mem_wa] <= mem_wd;
      end
      rda_ff <= regs_ff[uop.ra];
      rdb_ff <= regs_ff[uop.rb];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pc_ff <= '0;
         ld_ff <= '0;
         last_ff <= '0;
         fresh_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  err_x_ff <= '0;
                  err_y_ff <= '0;
                  err_z_ff <= '0;
                  if (skip) begin
                     fresh_ff <= 1'b0;
                     state_ff <= S_DONE;
                  end else begin
                     fresh_ff <= 1'b1;
                     last_ff <= req_sample_count;
                     q0_ff <= req_quat_w;
                     q1_ff <= req_quat_x;
                     q2_ff <= req_quat_y;
                     q3_ff <= req_quat_z;
                     f0_ff <= req_field_x;
                     f1_ff <= req_field_y;
                     f2_ff <= req_field_z;
                     ld_ff <= '0;
                     state_ff <= S_LOAD;
                  end
               end
            end
            S_LOAD: begin
               ld_ff <= ld_ff + 3'd1;
               if (ld_ff == 3'd6) begin
                  pc_ff <= '0;
                  state_ff <= S_FETCH;
               end
            end
            S_FETCH: begin
               case (uop.kind)
                  OP_MAC: state_ff <= S_MUL;
                  OP_SQRT, OP_SQRT30: state_ff <= S_SQRT;
                  OP_DIV: state_ff <= S_DSTART;
                  OP_CHKZ: begin
                     if (s_ff == '0) begin
                        state_ff <= S_DONE;
                     end else begin
                        pc_ff <= pc_ff + 6'd1;
                     end
                  end
                  default: state_ff <= S_DONE;
               endcase
            end
            S_MUL: begin
               state_ff <= S_ACC;
            end
            S_ACC: begin
               acc_ff <= acc_in;
               if (uop.wr) begin
                  case (uop.dst)
                     A_E0: err_x_ff <= acc_sat;
                     A_E1: err_y_ff <= acc_sat;
                     A_E2: err_z_ff <= acc_sat;
                     default: ;
                  endcase
               end
               pc_ff <= pc_ff + 6'd1;
               state_ff <= S_FETCH;
            end
            S_SQRT: begin
               if (!sq_busy) begin
                  s_ff <= sq_root;
                  pc_ff <= pc_ff + 6'd1;
                  state_ff <= S_FETCH;
               end
            end
            S_DSTART: begin
               neg_ff <= rda_ff[WORD_W-1];
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (!dv_busy) begin
                  pc_ff <= pc_ff + 6'd1;
                  state_ff <= S_FETCH;
               end
            end
            S_DONE: begin
               if (rsp_ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);
   assign rsp_err_x = err_x_ff;
   assign rsp_err_y = err_y_ff;
   assign rsp_err_z = err_z_ff;
   assign rsp_fresh = fresh_ff;

   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !req_ready)
      else $error("A new request was offered while a response was pending.");

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_sample_count == last_ff) |=> (rsp_valid && !rsp_fresh))
      else $error("A repeated sample count was not skipped at once.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_fresh) |-> (rsp_err_x == '0 && rsp_err_y == '0 && rsp_err_z == '0))
      else $error("A skipped request gave a nonzero error.");

   assert property (@(posedge clock) disable iff (reset) !(sq_busy && dv_busy))
      else $error("The square root and divider units ran together.");

endmodule
`default_nettype wire

FILE: tb/sv/tb_magnetic_heading_error_unit.sv
`default_nettype none
module tb_magnetic_heading_error_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC = 30;
   localparam longint ONE = longint'(1) << FRAC;
   localparam int STALL_LIMIT = 20000;
   localparam int RANDOM_ITEMS = 1850;

   typedef struct {
      logic signed [31:0] qw, qx, qy, qz;
      logic signed [15:0] fx, fy, fz;
      logic [7:0]         cnt;
   } sample_type;

   typedef struct {
      logic signed [31:0] ex, ey, ez;
      logic               fresh;
   } heading_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_quat_w = '0, req_quat_x = '0, req_quat_y = '0, req_quat_z = '0;
   logic signed [15:0] req_field_x = '0, req_field_y = '0, req_field_z = '0;
   logic [7:0] req_sample_count = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_err_x, rsp_err_y, rsp_err_z;
   logic rsp_fresh;

   sample_type  pending_samples[$];
   heading_type expected_headings[$];
   logic [7:0] model_last_count = '0;
   int errors = 0;
   int accepted = 0;
   int idle_cycles = 0;
   logic stimulus_done = 1'b0;

   magnetic_heading_error_unit DUT (.*);

   always #5 clock = ~clock;

   function automatic longint clip32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint qmul(input longint a, input longint b);
      return (a * b + (longint'(1) << (FRAC - 1))) >>> FRAC;
   endfunction

   function automatic longint unsigned floor_sqrt(input longint unsigned x);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic heading_type predict_heading(input sample_type s);
      heading_type h;
      longint q0, q1, q2, q3, r, hx, hy, bx, bz, sd;
      longint f[3], u[3], w[3], v[3];
      longint q11, q22, q33, q01, q02, q03, q12, q13, q23;
      longint a11, a12, a13, a21, a22, a23, a31, a32, a33;
      longint unsigned n2;
      h.ex = 0; h.ey = 0; h.ez = 0; h.fresh = 1'b0;
      f[0] = s.fx; f[1] = s.fy; f[2] = s.fz;
      if (s.cnt == model_last_count || (f[0] == 0 && f[1] == 0 && f[2] == 0)) return h;
      model_last_count = s.cnt;
      h.fresh = 1'b1;
      q0 = s.qw; q1 = s.qx; q2 = s.qy; q3 = s.qz;
      n2 = longint'(f[0] * f[0] + f[1] * f[1] + f[2] * f[2]);
      r = longint'(floor_sqrt(n2 << 30));
      for (int k = 0; k < 3; k++) u[k] = clip32((f[k] * (longint'(1) << (FRAC + 15))) / r);
      q11 = qmul(q1, q1); q22 = qmul(q2, q2); q33 = qmul(q3, q3);
      q01 = qmul(q0, q1); q02 = qmul(q0, q2); q03 = qmul(q0, q3);
      q12 = qmul(q1, q2); q13 = qmul(q1, q3); q23 = qmul(q2, q3);
      a11 = clip32(ONE - 2 * q22 - 2 * q33);
      a12 = clip32(2 * (q12 - q03));
      a13 = clip32(2 * (q13 + q02));
      a21 = clip32(2 * (q12 + q03));
      a22 = clip32(ONE - 2 * q11 - 2 * q33);
      a23 = clip32(2 * (q23 - q01));
      a31 = clip32(2 * (q13 - q02));
      a32 = clip32(2 * (q23 + q01));
      a33 = clip32(ONE - 2 * q11 - 2 * q22);
      hx = clip32(qmul(a11, u[0]) + qmul(a12, u[1]) + qmul(a13, u[2]));
      hy = clip32(qmul(a21, u[0]) + qmul(a22, u[1]) + qmul(a23, u[2]));
      bz = clip32(qmul(a31, u[0]) + qmul(a32, u[1]) + qmul(a33, u[2]));
      n2 = longint'(unsigned'(hx * hx)) + longint'(unsigned'(hy * hy));
      bx = clip32(longint'(floor_sqrt(n2)));
      w[0] = clip32(qmul(bx, a11) + qmul(bz, a31));
      w[1] = clip32(qmul(bx, a12) + qmul(bz, a32));
      w[2] = clip32(qmul(bx, a13) + qmul(bz, a33));
      n2 = 64'(w[0] * w[0]) + 64'(w[1] * w[1]) + 64'(w[2] * w[2]);
      sd = longint'(floor_sqrt(n2));
      if (sd != 0) begin
         for (int k = 0; k < 3; k++) v[k] = clip32((w[k] * ONE) / sd);
         h.ex = 32'(clip32(qmul(u[1], v[2]) - qmul(u[2], v[1])));
         h.ey = 32'(clip32(qmul(u[2], v[0]) - qmul(u[0], v[2])));
         h.ez = 32'(clip32(qmul(u[0], v[1]) - qmul(u[1], v[0])));
      end
      return h;
   endfunction

   function automatic sample_type make_sample(input logic [31:0] w, x, y, z,
                                              input logic [15:0] fx, fy, fz,
                                              input logic [7:0] c);
      sample_type s;
      s.qw = w; s.qx = x; s.qy = y; s.qz = z;
      s.fx = fx; s.fy = fy; s.fz = fz; s.cnt = c;
      return s;
   endfunction

   // Sender: bursts of random length separated by random gaps.
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      sample_type s;
      logic take;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         take = 1'b0;
         if (req_valid && req_ready) begin
            expected_headings.push_back(predict_heading(pending_samples.pop_front()));
            take = 1'b1;
         end
         if (req_valid && !take) begin
            req_valid <= 1'b1;
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_samples.size() == 0) begin
            req_valid <= 1'b0;
         end else begin
            s = pending_samples[0];
            req_valid <= 1'b1;
            req_quat_w <= s.qw; req_quat_x <= s.qx; req_quat_y <= s.qy; req_quat_z <= s.qz;
            req_field_x <= s.fx; req_field_y <= s.fy; req_field_z <= s.fz;
            req_sample_count <= s.cnt;
            if (burst_left > 0) begin
               burst_left <= burst_left - 1;
            end else begin
               burst_left <= $urandom_range(0, 12);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
            end
         end
      end
   end

   // Receiver: its own stall pattern, and one long hold-off.
   int phase = 0;
   int hold_left = 0;
   logic hold_done = 1'b0;
   always @(posedge clock) begin
      heading_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            accepted <= accepted + 1;
            if (expected_headings.size() == 0) begin
               errors <= errors + 1;
               $display("%0t: response with no request outstanding", $time);
            end else begin
               e = expected_headings.pop_front();
               if (rsp_err_x !== e.ex || rsp_err_y !== e.ey || rsp_err_z !== e.ez
                   || rsp_fresh !== e.fresh) begin
                  errors <= errors + 1;
                  $display("%0t: mismatch expected %0d %0d %0d fresh %b, actual %0d %0d %0d fresh %b",
                           $time, e.ex, e.ey, e.ez, e.fresh,
                           rsp_err_x, rsp_err_y, rsp_err_z, rsp_fresh);
               end
            end
         end
         phase <= phase + 1;
         if (!hold_done && accepted == 300) begin
            hold_done <= 1'b1;
            hold_left <= 3000;
            rsp_ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else if ((phase / 512) % 3 == 0) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= (((phase * 7) % 11) > 3) && ($urandom_range(0, 3) != 0);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset || stimulus_done)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic logic [31:0] random_quat_part(input int mode);
      case (mode)
         0: return $urandom;
         1: return $urandom_range(0, 32'h7FFF_FFFF) - 32'h4000_0000;
         default: return 32'($signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000);
      endcase
   endfunction

   initial begin
      sample_type s;
      logic [7:0] c;
      real a, b, d, g, n;
      int mode;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      // Count equal to the reset value is skipped.
      pending_samples.push_back(make_sample(32'h4000_0000, 0, 0, 0, 100, 200, 300, 8'd0));
      pending_samples.push_back(make_sample(32'h4000_0000, 0, 0, 0, 100, 200, 300, 8'd1));
      pending_samples.push_back(make_sample(32'h4000_0000, 0, 0, 0, 5, 6, 7, 8'd1));
      // A new count with an all-zero sample is skipped and not recorded.
      pending_samples.push_back(make_sample(32'h4000_0000, 0, 0, 0, 0, 0, 0, 8'd2));
      pending_samples.push_back(make_sample(32'h4000_0000, 0, 0, 0, 1, 0, 0, 8'd2));
      pending_samples.push_back(make_sample(0, 32'h4000_0000, 0, 0, 0, 1, 0, 8'd3));
      pending_samples.push_back(make_sample(0, 0, 32'h4000_0000, 0, 0, 0, 16'hFFFF, 8'd4));
      pending_samples.push_back(make_sample(32'h2D41_3CCD, 32'h2D41_3CCD, 0, 0,
                                            16'h7FFF, 16'h7FFF, 16'h7FFF, 8'd255));
      pending_samples.push_back(make_sample(32'h2000_0000, 32'h2000_0000, 32'h2000_0000,
                                            32'h2000_0000, 16'h8000, 16'h8000, 16'h8000, 8'd0));
      pending_samples.push_back(make_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                            32'h7FFF_FFFF, 16'h7FFF, 16'h8000, 1, 8'd10));
      pending_samples.push_back(make_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                            32'h8000_0000, 16'h8000, 16'h7FFF, 0, 8'd11));
      pending_samples.push_back(make_sample(0, 0, 0, 0, 300, 16'hFE70, 500, 8'd12));
      pending_samples.push_back(make_sample(32'h8000_0000, 0, 32'h7FFF_FFFF, 0,
                                            0, 16'h8000, 0, 8'd13));
      pending_samples.push_back(make_sample(0, 32'h2D41_3CCD, 32'h2D41_3CCD, 0,
                                            16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd14));
      pending_samples.push_back(make_sample(32'hC000_0000, 0, 0, 32'h4000_0000,
                                            1, 1, 1, 8'd15));
      c = 8'd15;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         mode = $urandom_range(0, 9);
         if (mode < 7) begin
            a = $urandom_range(0, 2000) - 1000.0; b = $urandom_range(0, 2000) - 1000.0;
            d = $urandom_range(0, 2000) - 1000.0; g = $urandom_range(0, 2000) - 1000.0;
            n = $sqrt(a * a + b * b + d * d + g * g);
            if (n == 0.0) begin a = 1.0; n = 1.0; end
            s.qw = $rtoi(a / n * 1073741823.0); s.qx = $rtoi(b / n * 1073741823.0);
            s.qy = $rtoi(d / n * 1073741823.0); s.qz = $rtoi(g / n * 1073741823.0);
         end else begin
            s.qw = random_quat_part(mode - 7); s.qx = random_quat_part(mode - 7);
            s.qy = random_quat_part(mode - 7); s.qz = random_quat_part(mode - 7);
         end
         if ($urandom_range(0, 3) == 0) begin
            s.fx = 16'($urandom); s.fy = 16'($urandom); s.fz = 16'($urandom);
         end else begin
            s.fx = 16'($urandom_range(0, 1200) - 600);
            s.fy = 16'($urandom_range(0, 1200) - 600);
            s.fz = 16'($urandom_range(0, 1200) - 600);
         end
         if ($urandom_range(0, 19) == 0) begin
            s.fx = 0; s.fy = 0; s.fz = 0;
         end
         mode = $urandom_range(0, 19);
         if (mode < 15) c = c + 8'd1;
         else if (mode < 18) c = c;
         else c = 8'($urandom);
         s.cnt = c;
         pending_samples.push_back(s);
      end
      wait (pending_samples.size() == 0 && !req_valid);
      wait (expected_headings.size() == 0);
      stimulus_done = 1'b1;
      repeat (700) @(posedge clock);
      if (errors == 0 && expected_headings.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
`default_nettype wire

FILE: files.f
hdl/mhe_pkg.sv
hdl/mhe_mul.sv
hdl/mhe_sqrt.sv
hdl/mhe_div.sv
hdl/magnetic_heading_error_unit.sv
tb/sv/tb_magnetic_heading_error_unit.sv
